### src/lsm_pkg.sv
// Shared types, constants and codes of the lidar sector minimum block.
package lsm_pkg;

  // Scan geometry
  localparam int unsigned NUM_SECTORS    = 12;
  localparam int unsigned BEAMS_PER_SCAN = 360;

  // Field widths
  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned BEAM_W   = 9;
  localparam int unsigned SECTOR_W = 4;
  localparam int unsigned HW_W     = 4;

  // Drain counter width, enough to index every sector
  localparam int unsigned CNT_W = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;

  // Width of the wrapped distance sum: beam + scan - centre + half width
  localparam int unsigned SUM_W = $clog2(3 * BEAMS_PER_SCAN + 16);

  // Reset values of the configuration registers
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 16'hFFFF;
  localparam logic [HW_W-1:0]    HALF_WIDTH_RST = 4'd10;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_RANGE  = 1'b0,
    CFG_HALF_WIDTH = 1'b1
  } cfg_idx_e;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } ctrl_state_e;

  // One beam sample
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [BEAM_W-1:0]  beam_index;
    logic               scan_end;
  } in_item_t;

  // One sector result
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [RANGE_W-1:0]  nearest_mm;
    logic                last_sector;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             upd;        // apply the accepted beam to the sectors
    logic             load;       // load the output register with sector idx
    logic             last;       // the loaded sector is the final one
    logic             clear_seen; // scan done, forget all hits
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_hold; // output register full and stalled
  } dp_status_t;

endpackage

### src/lsm_ctrl.sv
// Controller of the lidar sector minimum block: accept beams, drain sectors.
module lsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                scan_end_i,
  output logic                in_stall_o,
  input  lsm_pkg::dp_status_t sts_i,
  output lsm_pkg::dp_cmd_t    cmd_o
);

  lsm_pkg::ctrl_state_e state_q, state_d;
  logic [lsm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic accept;

  // State and drain counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsm_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign accept = in_valid_i && (state_q == lsm_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    in_stall_o       = 1'b1;
    cmd_o            = '0;
    cmd_o.idx        = cnt_q;
    cmd_o.last       = (cnt_q == lsm_pkg::CNT_W'(lsm_pkg::NUM_SECTORS - 1));
    unique case (state_q)
      lsm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.upd  = accept;
        if (accept && scan_end_i) begin
          state_d = lsm_pkg::ST_DRAIN;
          cnt_d   = '0;
        end
      end
      lsm_pkg::ST_DRAIN: begin
        // one sector per cycle while the output register can take it
        if (!sts_i.out_hold) begin
          cmd_o.load = 1'b1;
          if (cmd_o.last) begin
            cmd_o.clear_seen = 1'b1;
            state_d          = lsm_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = lsm_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_upd_while_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.upd && cmd_o.load))
    else $error("beam update during sector drain");
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsm_pkg::ST_DRAIN) |-> (cnt_q < lsm_pkg::CNT_W'(lsm_pkg::NUM_SECTORS)))
    else $error("drain counter beyond last sector");
  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && cmd_o.last) |=> (state_q == lsm_pkg::ST_IDLE && !in_stall_o))
    else $error("no return to idle after final sector");
`endif

endmodule

### src/lsm_datapath.sv
// Datapath of the lidar sector minimum block: sector lanes, config, output register.
module lsm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  lsm_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [lsm_pkg::RANGE_W-1:0]  cfg_wdata_i,
  input  lsm_pkg::in_item_t            in_item_i,
  input  lsm_pkg::dp_cmd_t             cmd_i,
  output lsm_pkg::dp_status_t          sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lsm_pkg::out_item_t           out_item_o
);

  localparam int unsigned N = lsm_pkg::NUM_SECTORS;
  localparam int unsigned B = lsm_pkg::BEAMS_PER_SCAN;

  logic [lsm_pkg::RANGE_W-1:0] max_range_q;
  logic [lsm_pkg::HW_W-1:0]    half_width_q;
  logic [lsm_pkg::RANGE_W-1:0] min_q [N];
  logic [N-1:0]                seen_q, seen_d, hit;
  logic                        beam_ok;
  logic                        out_valid_q, out_valid_d;
  lsm_pkg::out_item_t          out_item_q;
  logic [lsm_pkg::RANGE_W-1:0] rd_min;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q  <= lsm_pkg::MAX_RANGE_RST;
      half_width_q <= lsm_pkg::HALF_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsm_pkg::CFG_MAX_RANGE:  max_range_q  <= cfg_wdata_i;
        lsm_pkg::CFG_HALF_WIDTH: half_width_q <= cfg_wdata_i[lsm_pkg::HW_W-1:0];
        default: ;
      endcase
    end
  end

  assign beam_ok = (lsm_pkg::SUM_W'(in_item_i.beam_index) < lsm_pkg::SUM_W'(B));

  // One lane per sector: window test and running minimum
  for (genvar k = 0; k < N; k++) begin : g_lane
    localparam int unsigned Centre = (k * B) / N;
    logic [lsm_pkg::SUM_W-1:0]   sum, wrap_ofs;
    logic [lsm_pkg::RANGE_W-1:0] cur;

    // distance from window start, wrapped into one scan
    always_comb begin
      sum = lsm_pkg::SUM_W'(in_item_i.beam_index) + lsm_pkg::SUM_W'(B - Centre)
          + lsm_pkg::SUM_W'(half_width_q);
      priority if (sum >= lsm_pkg::SUM_W'(2 * B)) wrap_ofs = sum - lsm_pkg::SUM_W'(2 * B);
      else if (sum >= lsm_pkg::SUM_W'(B))          wrap_ofs = sum - lsm_pkg::SUM_W'(B);
      else                                         wrap_ofs = sum;
    end

    assign hit[k] = cmd_i.upd && beam_ok
                  && (wrap_ofs < lsm_pkg::SUM_W'({half_width_q, 1'b0}));
    assign cur    = seen_q[k] ? min_q[k] : max_range_q;

    always_ff @(posedge clk_i) begin
      if (hit[k]) begin
        min_q[k] <= (in_item_i.range_mm < cur) ? in_item_i.range_mm : cur;
      end
    end
  end

  // Hit flags, cleared once the scan is drained
  assign seen_d = cmd_i.clear_seen ? '0 : (seen_q | hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // Output register
  assign rd_min      = seen_q[cmd_i.idx] ? min_q[cmd_i.idx] : max_range_q;
  assign sts_o.out_hold = out_valid_q && out_stall_i;
  assign out_valid_d = cmd_i.load || sts_o.out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_item_q.sector      <= lsm_pkg::SECTOR_W'(cmd_i.idx);
      out_item_q.nearest_mm  <= rd_min;
      out_item_q.last_sector <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_clear_empties_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_seen |=> (seen_q == '0))
    else $error("hit flags not cleared at end of scan");
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");
  a_bad_beam_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd && !beam_ok) |=> $stable(seen_q))
    else $error("out of range beam marked a sector");
`endif

endmodule

### src/lidar_sector_minimum.sv
// Top level of the lidar sector minimum block.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one beam sample per
// item with its beam index and an end-of-scan flag. Output channel
// (out_valid_o / out_stall_i / out_item_o): per-sector minimum range results.
// Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): max_range and half_width,
// to be written while the block is idle; the block does not enforce it.
// Beams stream at one per cycle while the block is idle. The item that ends a
// scan starts a drain of all NUM_SECTORS results, one per cycle through the
// output register while the receiver does not stall; the first result is
// valid once the controller has entered the drain state and loaded the output
// register. No new beam is taken during the drain. A stall from the receiver
// holds the output register and pauses the drain counter.
// Reset clears all hit flags, empties the output register and sets
// max_range to 65535 and half_width to 10; sectors not hit in a scan report
// the current max_range.
module lidar_sector_minimum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lsm_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lsm_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  lsm_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [lsm_pkg::RANGE_W-1:0] cfg_wdata_i
);

  lsm_pkg::dp_cmd_t    cmd;
  lsm_pkg::dp_status_t sts;

  lsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .scan_end_i (in_item_i.scan_end),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
